>>> rtl/core/hff_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RGB565 hole-fill filter.
// No dependencies.
package hff_pkg;

    localparam int FRAME_WIDTH_DEF  = 64;
    localparam int FRAME_HEIGHT_DEF = 64;

    localparam int PIX_W = 16;
    localparam int POS_W = 6;

    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 5;

    // x / 5 == (x * 205) >> 10 for x < 1024
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        NB_CENTRE = 3'd0,
        NB_RIGHT  = 3'd1,
        NB_DOWN   = 3'd2,
        NB_LEFT   = 3'd3,
        NB_UP     = 3'd4
    } nb_sel_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

endpackage

>>> rtl/core/hff_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module hff_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> rtl/core/hff_accum.sv
`timescale 1ns / 1ps
// Per-channel neighbour accumulator and divide-by-five for hole filling.
// Depends on hff_pkg.
module hff_accum (
    input  logic                         aclk,
    input  hff_pkg::acc_ctrl_t           ctrl,
    input  logic [hff_pkg::PIX_W-1:0]    pixel,
    output logic [hff_pkg::PIX_W-1:0]    avg_pixel
);

    logic [6:0]  red_reg,   red_next;
    logic [7:0]  green_reg, green_next;
    logic [6:0]  blue_reg,  blue_next;
    logic [14:0] red_prod;
    logic [15:0] green_prod;
    logic [14:0] blue_prod;

    always_comb begin
        priority if (ctrl.clear) begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end else if (ctrl.add) begin
            red_next   = red_reg + 7'(pixel[15:11]);
            green_next = green_reg + 8'(pixel[10:5]);
            blue_next  = blue_reg + 7'(pixel[4:0]);
        end else begin
            red_next   = red_reg;
            green_next = green_reg;
            blue_next  = blue_reg;
        end
    end

    always_ff @(posedge aclk) begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign red_prod   = 15'(red_reg) * 15'(hff_pkg::DIV5_MUL);
    assign green_prod = 16'(green_reg) * 16'(hff_pkg::DIV5_MUL);
    assign blue_prod  = 15'(blue_reg) * 15'(hff_pkg::DIV5_MUL);

    assign avg_pixel = {red_prod[14:hff_pkg::DIV5_SHIFT],
                        green_prod[15:hff_pkg::DIV5_SHIFT],
                        blue_prod[14:hff_pkg::DIV5_SHIFT]};

endmodule

>>> rtl/core/rgb565_hole_fill_filter_unit.sv
`timescale 1ns / 1ps
// Top level of the RGB565 hole-fill filter: frame RAM, fetch sequencer, output register.
// Depends on hff_pkg, hff_ram, hff_accum.
//
// Input channel s_*: one beat is a write (store s_pixel_in at s_pos_x, s_pos_y) or a
// read (return the filtered pixel there). Writes outside the frame are dropped.
// Output channel m_*: one beat per read, in order; writes give no beat.
// Border and out-of-frame reads return zero. A non-zero interior pixel passes
// through; a black one becomes the per-channel sum of its four neighbours / 5.
// One item is handled at a time; a write is done as soon as it is taken. A
// border read skips the RAM, a non-black interior read ends once the centre
// pixel returns and a black one fetches all four neighbours: the single RAM
// port makes one access per cycle (centre, then right, down, left, up). The
// result is loaded into the m_* output register once that register is free.
// While m_ready is low the held result stays put; writes are still taken, and
// a further read completes its fetch and waits until the register frees.
// Reset clears the control state and drops any held result. The frame RAM is
// not cleared; pixels must be written before they are read.
module rgb565_hole_fill_filter_unit #(
    parameter int FRAME_WIDTH  = hff_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = hff_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [hff_pkg::POS_W-1:0]     s_pos_x,
    input  logic [hff_pkg::POS_W-1:0]     s_pos_y,
    input  logic [hff_pkg::PIX_W-1:0]     s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hff_pkg::PIX_W-1:0]     m_pixel_out
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(((FRAME_WIDTH > FRAME_HEIGHT) ?
                                   FRAME_WIDTH : FRAME_HEIGHT) + 64);

    hff_pkg::state_t            state_reg, state_next;
    hff_pkg::nb_sel_t           idx_reg, idx_next;
    hff_pkg::nb_sel_t           tag_reg, tag_next;
    logic                       tag_vld_reg, tag_vld_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [hff_pkg::PIX_W-1:0]  centre_reg, centre_next;
    logic                       hole_reg, hole_next;
    logic                       zero_reg, zero_next;
    logic                       m_valid_reg, m_valid_next;
    logic [hff_pkg::PIX_W-1:0]  m_pixel_out_reg, m_pixel_out_next;

    logic [CW-1:0]              x_ext, y_ext;
    logic                       in_frame, on_border;
    logic [AW-1:0]              pix_addr, nb_addr, ram_addr;
    logic                       ram_we;
    logic [hff_pkg::PIX_W-1:0]  ram_rdata, avg_pixel;
    hff_pkg::acc_ctrl_t         acc_ctrl;

    assign x_ext     = CW'(s_pos_x);
    assign y_ext     = CW'(s_pos_y);
    assign in_frame  = (x_ext < CW'(FRAME_WIDTH)) && (y_ext < CW'(FRAME_HEIGHT));
    assign on_border = (x_ext == '0) || (y_ext == '0) ||
                       (x_ext >= CW'(FRAME_WIDTH - 1)) || (y_ext >= CW'(FRAME_HEIGHT - 1));
    assign pix_addr  = AW'(s_pos_y) * AW'(FRAME_WIDTH) + AW'(s_pos_x);

    always_comb begin
        unique case (idx_reg)
            hff_pkg::NB_CENTRE: nb_addr = addr_reg;
            hff_pkg::NB_RIGHT:  nb_addr = addr_reg + AW'(1);
            hff_pkg::NB_DOWN:   nb_addr = addr_reg + AW'(FRAME_WIDTH);
            hff_pkg::NB_LEFT:   nb_addr = addr_reg - AW'(1);
            hff_pkg::NB_UP:     nb_addr = addr_reg - AW'(FRAME_WIDTH);
            default:            nb_addr = addr_reg;
        endcase
    end

    assign s_ready = (state_reg == hff_pkg::ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        tag_next         = tag_reg;
        tag_vld_next     = 1'b0;
        addr_next        = addr_reg;
        centre_next      = centre_reg;
        hole_next        = hole_reg;
        zero_next        = zero_reg;
        m_valid_next     = m_valid_reg & ~m_ready;
        m_pixel_out_next = m_pixel_out_reg;
        ram_we           = 1'b0;
        ram_addr         = nb_addr;
        acc_ctrl         = '0;

        unique case (state_reg)
            hff_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == hff_pkg::OP_WRITE) begin
                        ram_we   = in_frame;
                        ram_addr = pix_addr;
                    end else begin
                        addr_next      = pix_addr;
                        idx_next       = hff_pkg::NB_CENTRE;
                        hole_next      = 1'b0;
                        zero_next      = on_border;
                        acc_ctrl.clear = 1'b1;
                        state_next     = on_border ? hff_pkg::ST_FINISH : hff_pkg::ST_FETCH;
                    end
                end
            end
            hff_pkg::ST_FETCH: begin
                tag_next     = idx_reg;
                tag_vld_next = 1'b1;
                idx_next     = hff_pkg::nb_sel_t'(idx_reg + 3'd1);
                if (idx_reg == hff_pkg::NB_UP) begin
                    state_next = hff_pkg::ST_LAST;
                end
            end
            hff_pkg::ST_LAST: begin
            end
            hff_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    priority if (zero_reg) begin
                        m_pixel_out_next = '0;
                    end else if (hole_reg) begin
                        m_pixel_out_next = avg_pixel;
                    end else begin
                        m_pixel_out_next = centre_reg;
                    end
                    state_next = hff_pkg::ST_IDLE;
                end
            end
            default: state_next = hff_pkg::ST_IDLE;
        endcase

        // returning read data, for the address issued in the previous cycle
        if (tag_vld_reg && ((state_reg == hff_pkg::ST_FETCH) ||
                            (state_reg == hff_pkg::ST_LAST))) begin
            priority if (tag_reg == hff_pkg::NB_CENTRE) begin
                if (ram_rdata != '0) begin
                    centre_next = ram_rdata;
                    state_next  = hff_pkg::ST_FINISH;
                end else begin
                    hole_next = 1'b1;
                end
            end else begin
                acc_ctrl.add = 1'b1;
                if (tag_reg == hff_pkg::NB_UP) begin
                    state_next = hff_pkg::ST_FINISH;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hff_pkg::ST_IDLE;
            tag_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tag_vld_reg <= tag_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        tag_reg         <= tag_next;
        addr_reg        <= addr_next;
        centre_reg      <= centre_next;
        hole_reg        <= hole_next;
        zero_reg        <= zero_next;
        m_pixel_out_reg <= m_pixel_out_next;
    end

    hff_ram #(
        .DATA_W (hff_pkg::PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_pixel_in),
        .rdata (ram_rdata)
    );

    hff_accum u_accum (
        .aclk      (aclk),
        .ctrl      (acc_ctrl),
        .pixel     (ram_rdata),
        .avg_pixel (avg_pixel)
    );

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;

endmodule

>>> rtl/core/hff_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the hole-fill filter, bound to its top level.
// Depends on hff_pkg and rgb565_hole_fill_filter_unit.
module hff_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_operation,
    input logic [hff_pkg::POS_W-1:0]     s_pos_x,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hff_pkg::PIX_W-1:0]     m_pixel_out
);

    logic rd_beat, wr_beat;

    assign rd_beat = s_valid && s_ready && (s_operation == hff_pkg::OP_READ);
    assign wr_beat = s_valid && s_ready && (s_operation == hff_pkg::OP_WRITE);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state not cleared by reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))
        else $error("stalled result beat changed");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_beat |=> !s_ready)
        else $error("read beat did not occupy the block");

    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_beat |=> s_ready)
        else $error("write beat took more than one cycle");

    a_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_beat && (s_pos_x == '0) && !m_valid |-> ##2 (m_valid && (m_pixel_out == '0)))
        else $error("left border read did not return zero");

endmodule

bind rgb565_hole_fill_filter_unit hff_checker u_hff_checker (.*);
